// ===== design/rbv_pkg.sv =====
// ----------------------------------------------------------------------------
// rbv_pkg: shared types and widths of the rigid-body velocity step
// Operand and product widths of the shared multiplier and the command and
// status bundles of the iterative divide / square-root unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rbv_pkg;

	// Signed multiplier operands and product.
	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;

	// Divide / square-root unit: 64-bit dividend or radicand, 32-bit divisor.
	localparam int DSU_N_W = 64;
	localparam int DSU_D_W = 32;

	// Command from the sequencer to the divide / square-root unit.
	typedef struct packed {
		logic go;
		logic sqrt;
	} dsu_ctl_t;

	// Status back from the divide / square-root unit.
	typedef struct packed {
		logic busy;
		logic done;
	} dsu_stat_t;

endpackage

`default_nettype wire

// ===== design/rbv_mul.sv =====
// ----------------------------------------------------------------------------
// rbv_mul: shared signed multiplier
// One signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module rbv_mul import rbv_pkg::*; (
	input  wire logic                     clk,
	input  wire logic signed [MUL_W-1:0]  a,
	input  wire logic signed [MUL_W-1:0]  b,
	output logic signed      [PROD_W-1:0] p
);

	// Product register, read by the sequencer in the cycle after issue.
	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

`default_nettype wire

// ===== design/rbv_dsu.sv =====
// ----------------------------------------------------------------------------
// rbv_dsu: iterative divide and square-root unit
// Signed 64-bit by unsigned 32-bit division truncated toward zero, one
// quotient bit per cycle, or a 64-bit integer square root, two radicand bits
// per cycle. Results stay valid until the next command.
// ----------------------------------------------------------------------------
`default_nettype none

module rbv_dsu import rbv_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire dsu_ctl_t                  ctl,
	input  wire logic        [DSU_N_W-1:0] dividend,
	input  wire logic        [DSU_D_W-1:0] divisor,
	output dsu_stat_t                      stat,
	output logic signed      [DSU_N_W-1:0] quotient,
	output logic             [DSU_D_W-1:0] root
);

	localparam int DIV_STEPS  = DSU_N_W;
	localparam int SQRT_STEPS = DSU_N_W / 2;
	localparam int CNT_W      = $clog2(DIV_STEPS + 1);
	localparam int REM_W      = DSU_D_W + 3;

	logic                busy_q;
	logic                done_q;
	logic                sqrt_q;
	logic                neg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DSU_N_W-1:0]  n_q;
	logic [REM_W-1:0]    rem_q;
	logic [DSU_D_W-1:0]  root_q;
	logic [DSU_D_W-1:0]  d_q;

	logic [DSU_N_W-1:0]  dividend_mag;
	logic [DSU_D_W:0]    div_rs;
	logic                div_ge;
	logic [REM_W-1:0]    sq_rs;
	logic [REM_W-1:0]    sq_trial;
	logic                sq_ge;

	// Magnitude of the signed dividend.
	assign dividend_mag = dividend[DSU_N_W-1] ? (~dividend + 1'b1) : dividend;

	// Restoring division step: bring down one dividend bit.
	assign div_rs = {rem_q[DSU_D_W-1:0], n_q[DSU_N_W-1]};
	assign div_ge = div_rs >= {1'b0, d_q};

	// Digit-by-digit square root step: bring down two radicand bits.
	assign sq_rs    = {rem_q[REM_W-3:0], n_q[DSU_N_W-1:DSU_N_W-2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = sq_rs >= sq_trial;

	// Control: step counter, busy and a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.go) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.sqrt ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift register, partial remainder and root.
	always_ff @(posedge clk) begin
		if (ctl.go) begin
			sqrt_q <= ctl.sqrt;
			neg_q  <= !ctl.sqrt && dividend[DSU_N_W-1];
			n_q    <= ctl.sqrt ? dividend : dividend_mag;
			d_q    <= divisor;
			rem_q  <= '0;
			if (ctl.sqrt) begin
				root_q <= '0;
			end
		end else if (busy_q) begin
			if (sqrt_q) begin
				rem_q  <= sq_ge ? (sq_rs - sq_trial) : sq_rs;
				root_q <= {root_q[DSU_D_W-2:0], sq_ge};
				n_q    <= {n_q[DSU_N_W-3:0], 2'b00};
			end else begin
				rem_q <= REM_W'(div_ge ? (div_rs - {1'b0, d_q}) : div_rs);
				n_q   <= {n_q[DSU_N_W-2:0], div_ge};
			end
		end
	end

	assign quotient  = neg_q ? $signed(~n_q + 1'b1) : $signed(n_q);
	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ===== design/rigid_body_velocity_step.sv =====
// ----------------------------------------------------------------------------
// rigid_body_velocity_step: 2D Euler velocity update with friction
// Keeps an accumulated force and a velocity in signed fixed point and steps
// the velocity one frame per tick transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): operation 0 adds force_x / force_y
//   to the saturating force accumulator; operation 1 steps one frame of
//   length frame_time. Every input transaction yields one output transaction
//   (velocity_x / velocity_y, the velocity after the item) on out_valid /
//   out_stall.
//   A tick runs on one shared multiplier and one iterative divide / square-root
//   unit: up to eight divisions and up to three square roots per tick. in_stall
//   is high from the accepting edge until the result has been loaded into the
//   output register. A finished result waits in the output register while
//   out_stall is high; the next input can be accepted meanwhile, and the
//   following result waits for the register to empty.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and belong between transactions. Reset clears force and velocity and
//   loads the default mass, friction, limits, gravity and ground flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rigid_body_velocity_step import rbv_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               operation,
	input  wire logic signed [31:0] force_x,
	input  wire logic signed [31:0] force_y,
	input  wire logic        [16:0] frame_time,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed      [31:0] velocity_x,
	output logic signed      [31:0] velocity_y,
	input  wire logic               cfg_we,
	input  wire logic        [2:0]  cfg_index,
	input  wire logic        [31:0] cfg_data
);

	localparam int UNIT_BITS = 30;
	localparam int FM_W      = 62 - FRAC_BITS;
	localparam int F_W       = 59 - FRAC_BITS;
	localparam int ACC_W     = 66;
	localparam int ST_W      = 47;
	localparam logic [PROD_W-1:0]     BIG_LIM = PROD_W'(1) << (FRAC_BITS + 2);
	localparam logic signed [ACC_W-1:0] S32_MAX = 66'sd2147483647;
	localparam logic signed [ACC_W-1:0] S32_MIN = -66'sd2147483648;

	typedef enum logic [2:0] {
		REG_MASS      = 3'd0,
		REG_FRICTION  = 3'd1,
		REG_SIDE_LIM  = 3'd2,
		REG_FALL_LIM  = 3'd3,
		REG_GRAV_X    = 3'd4,
		REG_GRAV_Y    = 3'd5,
		REG_ON_GROUND = 3'd6
	} cfg_reg_t;

	typedef enum logic [ST_W-1:0] {
		S_IDLE = 47'd1 << 0,  S_FMX  = 47'd1 << 1,  S_FDX  = 47'd1 << 2,
		S_FMY  = 47'd1 << 3,  S_FDY  = 47'd1 << 4,  S_GSX  = 47'd1 << 5,
		S_GSY  = 47'd1 << 6,  S_GSQ  = 47'd1 << 7,  S_UX   = 47'd1 << 8,
		S_UY   = 47'd1 << 9,  S_UYD  = 47'd1 << 10, S_GND  = 47'd1 << 11,
		S_AX   = 47'd1 << 12, S_AY   = 47'd1 << 13, S_AZ   = 47'd1 << 14,
		S_P1   = 47'd1 << 15, S_P2   = 47'd1 << 16, S_P3   = 47'd1 << 17,
		S_P4   = 47'd1 << 18, S_P5   = 47'd1 << 19, S_P6   = 47'd1 << 20,
		S_LIM  = 47'd1 << 21, S_LX   = 47'd1 << 22, S_LY   = 47'd1 << 23,
		S_SS1  = 47'd1 << 24, S_SS2  = 47'd1 << 25, S_SS3  = 47'd1 << 26,
		S_SL   = 47'd1 << 27, S_SDX  = 47'd1 << 28, S_SMY  = 47'd1 << 29,
		S_SDY  = 47'd1 << 30, S_SDYD = 47'd1 << 31, S_SUM  = 47'd1 << 32,
		S_FR0  = 47'd1 << 33, S_FR1  = 47'd1 << 34, S_FR2  = 47'd1 << 35,
		S_FR3  = 47'd1 << 36, S_FR4  = 47'd1 << 37, S_FR5  = 47'd1 << 38,
		S_FR6  = 47'd1 << 39, S_FR7  = 47'd1 << 40, S_FR8  = 47'd1 << 41,
		S_FR9  = 47'd1 << 42, S_FR10 = 47'd1 << 43, S_FR11 = 47'd1 << 44,
		S_WAIT = 47'd1 << 45, S_DONE = 47'd1 << 46
	} state_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Reset value k in fixed point, saturated to the 31-bit register range.
	function automatic logic [30:0] scaled_reset(input logic [63:0] k);
		logic [63:0] v;
		v = k << FRAC_BITS;
		return (v > 64'h7FFFFFFF) ? 31'h7FFFFFFF : v[30:0];
	endfunction

	// Configuration registers.
	logic        [30:0] mass_q, fric_q, side_lim_q, fall_lim_q;
	logic signed [31:0] grav_x_q, grav_y_q;
	logic               on_ground_q;

	// Architectural state.
	logic signed [31:0] facc_x_q, facc_y_q, vel_x_q, vel_y_q;

	// Sequencer.
	state_t state_q, state_d, ret_q, ret_d;

	// Working registers of a tick.
	logic               tick_q;
	logic        [16:0] dt_q;
	logic signed [31:0] vx_q, vy_q, ux_q, uy_q, sx_q, sy_q;
	logic        [31:0] len_q;
	logic signed [32:0] p_q;
	logic signed [33:0] fx_q, fy_q;
	logic signed [ACC_W-1:0] acc_q;
	logic        [FM_W-1:0]  fm_q;
	logic        [F_W-1:0]   f_q;
	logic               big_q;
	logic               pass_q;

	// Output register.
	logic               out_valid_q;
	logic signed [31:0] ovx_q, ovy_q;

	// Shared units.
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  prod66;
	dsu_ctl_t                 dsu_ctl;
	dsu_stat_t                dsu_stat;
	logic        [DSU_N_W-1:0] dsu_dividend;
	logic        [DSU_D_W-1:0] dsu_divisor;
	logic signed [DSU_N_W-1:0] quo;
	logic        [DSU_D_W-1:0] root;

	// Derived values.
	logic               in_acc;
	logic        [30:0] meff;
	logic signed [MUL_W-1:0] dt34;
	logic signed [ACC_W-1:0] sum66;
	logic signed [32:0] lim_s;
	logic        [32:0] p_mag;
	logic signed [33:0] fproj;
	logic        [FM_W-1:0]  fm_now;
	logic        [ACC_W-1:0] ftot;

	assign in_acc  = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign meff    = (mass_q == 31'd0) ? 31'd1 : mass_q;
	assign dt34    = $signed({17'b0, dt_q});
	assign prod66  = prod[ACC_W-1:0];
	assign sum66   = acc_q + prod66;
	assign lim_s   = p_q[32] ? -$signed({2'b0, fall_lim_q}) : $signed({2'b0, fall_lim_q});
	assign p_mag   = p_q[32] ? $unsigned(-p_q) : $unsigned(p_q);
	assign fproj   = 34'(prod66 >>> UNIT_BITS);
	assign fm_now  = FM_W'(prod[61:0] >> FRAC_BITS);
	assign ftot    = $unsigned(acc_q) + {prod66[33:0], 32'b0};

	rbv_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	rbv_dsu u_dsu (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dsu_ctl),
		.dividend (dsu_dividend),
		.divisor  (dsu_divisor),
		.stat     (dsu_stat),
		.quotient (quo),
		.root     (root)
	);

	// Multiplier operand selection for each sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_FMX: begin mul_a = 34'(facc_x_q); mul_b = dt34; end
			S_FMY: begin mul_a = 34'(facc_y_q); mul_b = dt34; end
			S_GSX: begin mul_a = 34'(grav_x_q); mul_b = 34'(grav_x_q); end
			S_GSY: begin mul_a = 34'(grav_y_q); mul_b = 34'(grav_y_q); end
			S_AX:  begin mul_a = 34'(grav_x_q); mul_b = dt34; end
			S_AY:  begin mul_a = 34'(grav_y_q); mul_b = dt34; end
			S_P1:  begin mul_a = 34'(ux_q); mul_b = 34'(vx_q); end
			S_P2:  begin mul_a = 34'(uy_q); mul_b = 34'(vy_q); end
			S_P4:  begin mul_a = 34'(ux_q); mul_b = 34'(p_q); end
			S_P5:  begin mul_a = 34'(uy_q); mul_b = 34'(p_q); end
			S_LIM: begin mul_a = 34'(ux_q); mul_b = 34'(lim_s); end
			S_LX:  begin mul_a = 34'(uy_q); mul_b = 34'(lim_s); end
			S_SS1: begin mul_a = 34'(sx_q); mul_b = 34'(sx_q); end
			S_SS2: begin mul_a = 34'(sy_q); mul_b = 34'(sy_q); end
			S_SL:  begin mul_a = 34'(sx_q); mul_b = $signed({3'b0, side_lim_q}); end
			S_SMY: begin mul_a = 34'(sy_q); mul_b = $signed({3'b0, side_lim_q}); end
			S_FR0: begin mul_a = $signed({3'b0, fric_q}); mul_b = $signed({3'b0, meff}); end
			S_FR1: begin mul_a = $signed({2'b0, fm_now[31:0]}); mul_b = dt34; end
			S_FR2: begin mul_a = $signed(34'(fm_q[FM_W-1:32])); mul_b = dt34; end
			S_FR4: begin mul_a = 34'(vx_q); mul_b = 34'(vx_q); end
			S_FR5: begin mul_a = 34'(vy_q); mul_b = 34'(vy_q); end
			S_FR7: begin mul_a = 34'(vx_q); mul_b = $signed({1'b0, f_q[32:0]}); end
			S_FR9: begin mul_a = 34'(vy_q); mul_b = $signed({1'b0, f_q[32:0]}); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Commands to the divide / square-root unit.
	always_comb begin
		dsu_ctl.go   = 1'b0;
		dsu_ctl.sqrt = 1'b0;
		dsu_dividend = prod[DSU_N_W-1:0];
		dsu_divisor  = len_q;
		case (state_q)
			S_FDX, S_FDY: begin
				dsu_ctl.go  = 1'b1;
				dsu_divisor = {1'b0, meff};
			end
			S_GSQ, S_SS3, S_FR6: begin
				dsu_ctl.go   = 1'b1;
				dsu_ctl.sqrt = 1'b1;
				dsu_dividend = sum66[DSU_N_W-1:0];
			end
			S_UX: begin
				dsu_ctl.go   = (root != '0);
				dsu_dividend = 64'(grav_x_q) <<< UNIT_BITS;
				dsu_divisor  = root;
			end
			S_UY: begin
				dsu_ctl.go   = 1'b1;
				dsu_dividend = 64'(grav_y_q) <<< UNIT_BITS;
			end
			S_SDX, S_SDY, S_FR8, S_FR10: begin
				dsu_ctl.go = 1'b1;
			end
			default: begin
				dsu_ctl.go = 1'b0;
			end
		endcase
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			S_IDLE: if (in_acc) begin
				state_d = operation ? S_FMX : S_DONE;
			end
			S_FMX:  state_d = S_FDX;
			S_FDX:  begin ret_d = S_FMY; state_d = S_WAIT; end
			S_FMY:  state_d = S_FDY;
			S_FDY:  begin ret_d = S_GSX; state_d = S_WAIT; end
			S_GSX:  state_d = S_GSY;
			S_GSY:  state_d = S_GSQ;
			S_GSQ:  begin ret_d = S_UX; state_d = S_WAIT; end
			S_UX: begin
				if (root == '0) begin
					state_d = S_GND;
				end else begin
					ret_d   = S_UY;
					state_d = S_WAIT;
				end
			end
			S_UY:   begin ret_d = S_UYD; state_d = S_WAIT; end
			S_UYD:  state_d = S_GND;
			S_GND:  state_d = on_ground_q ? S_P1 : S_AX;
			S_AX:   state_d = S_AY;
			S_AY:   state_d = S_AZ;
			S_AZ:   state_d = S_P1;
			S_P1:   state_d = S_P2;
			S_P2:   state_d = S_P3;
			S_P3:   state_d = S_P4;
			S_P4:   state_d = S_P5;
			S_P5:   state_d = S_P6;
			S_P6:   state_d = pass_q ? S_LIM : S_P1;
			S_LIM:  state_d = (p_mag > {2'b0, fall_lim_q}) ? S_LX : S_SS1;
			S_LX:   state_d = S_LY;
			S_LY:   state_d = S_SS1;
			S_SS1:  state_d = S_SS2;
			S_SS2:  state_d = S_SS3;
			S_SS3:  begin ret_d = S_SL; state_d = S_WAIT; end
			S_SL:   state_d = (root > {1'b0, side_lim_q}) ? S_SDX : S_SUM;
			S_SDX:  begin ret_d = S_SMY; state_d = S_WAIT; end
			S_SMY:  state_d = S_SDY;
			S_SDY:  begin ret_d = S_SDYD; state_d = S_WAIT; end
			S_SDYD: state_d = S_SUM;
			S_SUM:  state_d = S_FR0;
			S_FR0:  state_d = (vx_q == '0 && vy_q == '0) ? S_DONE : S_FR1;
			S_FR1:  state_d = S_FR2;
			S_FR2:  state_d = S_FR3;
			S_FR3:  state_d = S_FR4;
			S_FR4:  state_d = S_FR5;
			S_FR5:  state_d = S_FR6;
			S_FR6:  begin ret_d = S_FR7; state_d = S_WAIT; end
			S_FR7: begin
				if (big_q || (F_W'(root) < f_q)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_FR8;
				end
			end
			S_FR8:  begin ret_d = S_FR9; state_d = S_WAIT; end
			S_FR9:  state_d = S_FR10;
			S_FR10: begin ret_d = S_FR11; state_d = S_WAIT; end
			S_FR11: state_d = S_DONE;
			S_WAIT: if (dsu_stat.done) begin
				state_d = ret_q;
			end
			S_DONE: if (!out_valid_q || !out_stall) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control state, configuration, force accumulator and velocity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			out_valid_q <= 1'b0;
			mass_q      <= scaled_reset(64'd1);
			fric_q      <= scaled_reset(64'd100);
			side_lim_q  <= scaled_reset(64'd200);
			fall_lim_q  <= scaled_reset(64'd1000);
			grav_x_q    <= '0;
			grav_y_q    <= $signed({1'b0, scaled_reset(64'd110)});
			on_ground_q <= 1'b1;
			facc_x_q    <= '0;
			facc_y_q    <= '0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;

			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MASS:      mass_q      <= cfg_data[30:0];
					REG_FRICTION:  fric_q      <= cfg_data[30:0];
					REG_SIDE_LIM:  side_lim_q  <= cfg_data[30:0];
					REG_FALL_LIM:  fall_lim_q  <= cfg_data[30:0];
					REG_GRAV_X:    grav_x_q    <= cfg_data;
					REG_GRAV_Y:    grav_y_q    <= cfg_data;
					REG_ON_GROUND: on_ground_q <= cfg_data[0];
					default:       on_ground_q <= on_ground_q;
				endcase
			end

			// An add-force transaction updates the accumulator on acceptance.
			if (in_acc && !operation) begin
				facc_x_q <= sat32(ACC_W'(facc_x_q) + ACC_W'(force_x));
				facc_y_q <= sat32(ACC_W'(facc_y_q) + ACC_W'(force_y));
			end

			// A finished tick commits its velocity.
			if (state_q == S_DONE && tick_q) begin
				vel_x_q <= vx_q;
				vel_y_q <= vy_q;
			end

			// Output register handshake.
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			ovx_q <= tick_q ? vx_q : vel_x_q;
			ovy_q <= tick_q ? vy_q : vel_y_q;
		end
	end

	// Working datapath of a tick.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			tick_q <= operation;
			dt_q   <= frame_time;
		end
		case (state_q)
			S_FMY: vx_q <= sat32(ACC_W'(vel_x_q) + ACC_W'(quo));
			S_GSX: vy_q <= sat32(ACC_W'(vel_y_q) + ACC_W'(quo));
			S_GSY: acc_q <= prod66;
			S_UX: begin
				len_q <= root;
				if (root == '0) begin
					ux_q <= '0;
					uy_q <= '0;
				end
			end
			S_UY:  ux_q <= quo[31:0];
			S_UYD: uy_q <= quo[31:0];
			S_GND: pass_q <= !on_ground_q;
			S_AY:  vx_q <= sat32(ACC_W'(vx_q) - (prod66 >>> FRAC_BITS));
			S_AZ: begin
				vy_q   <= sat32(ACC_W'(vy_q) - (prod66 >>> FRAC_BITS));
				pass_q <= 1'b1;
			end
			S_P2:  acc_q <= prod66;
			S_P3:  p_q   <= 33'(sum66 >>> UNIT_BITS);
			S_P5:  fx_q  <= fproj;
			S_P6: begin
				// First pass removes the ground-normal part, second splits.
				if (!pass_q) begin
					vx_q   <= sat32(ACC_W'(vx_q) - ACC_W'(fx_q));
					vy_q   <= sat32(ACC_W'(vy_q) - ACC_W'(fproj));
					pass_q <= 1'b1;
				end else begin
					sx_q <= sat32(ACC_W'(vx_q) - ACC_W'(fx_q));
					sy_q <= sat32(ACC_W'(vy_q) - ACC_W'(fproj));
					fy_q <= fproj;
				end
			end
			S_LX:   fx_q  <= fproj;
			S_LY:   fy_q  <= fproj;
			S_SS2:  acc_q <= prod66;
			S_SL:   len_q <= root;
			S_SMY:  sx_q  <= quo[31:0];
			S_SDYD: sy_q  <= quo[31:0];
			S_SUM: begin
				vx_q <= sat32(ACC_W'(fx_q) + ACC_W'(sx_q));
				vy_q <= sat32(ACC_W'(fy_q) + ACC_W'(sy_q));
			end
			S_FR1: fm_q  <= fm_now;
			S_FR2: acc_q <= prod66;
			S_FR3: begin
				// Friction beyond any reachable speed simply stops the body.
				big_q <= $unsigned(prod) >= BIG_LIM;
				f_q   <= F_W'(ftot >> FRAC_BITS);
			end
			S_FR5: acc_q <= prod66;
			S_FR7: begin
				len_q <= root;
				if (big_q || (F_W'(root) < f_q)) begin
					vx_q <= '0;
					vy_q <= '0;
				end
			end
			S_FR9:  vx_q <= vx_q - quo[31:0];
			S_FR11: vy_q <= vy_q - quo[31:0];
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign velocity_x = ovx_q;
	assign velocity_y = ovy_q;

	// The divide / square-root unit is never commanded while it is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		dsu_ctl.go |-> !dsu_stat.busy)
		else $error("divide/sqrt command issued while unit busy");

	// While waiting, the unit is either running or just finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT) |-> (dsu_stat.busy || dsu_stat.done))
		else $error("sequencer waits on an idle divide/sqrt unit");

	// A result appears only when the sequencer has finished an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the completion step");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of rigid_body_velocity_step
// Drives add-force and tick transactions through the valid/stall channels,
// predicts every velocity with a fixed-point model of its own and checks each
// output transaction in order. Runs a short directed table and then random
// phases under several register settings and idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import rbv_pkg::*;

	typedef enum logic {OP_ADD_FORCE = 1'b0, OP_TICK = 1'b1} op_e;
	typedef enum logic [2:0] {
		REG_MASS = 3'd0, REG_FRICTION = 3'd1, REG_SIDE_LIMIT = 3'd2,
		REG_FALL_LIMIT = 3'd3, REG_GRAVITY_X = 3'd4, REG_GRAVITY_Y = 3'd5,
		REG_ON_GROUND = 3'd6
	} reg_e;

	localparam int FRAC = 16;
	localparam int UNIT = 30;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 5000000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 242;
	localparam int HOLD_CYCLES = 1500;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
	} velocity_t;

	typedef struct {
		op_e         op;
		logic [31:0] fx;
		logic [31:0] fy;
		logic [16:0] dt;
		bit          typed;
		logic [31:0] ex;
		logic [31:0] ey;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               operation;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic        [16:0] frame_time;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] velocity_x;
	logic signed [31:0] velocity_y;
	logic               cfg_we;
	logic        [2:0]  cfg_index;
	logic        [31:0] cfg_data;

	rigid_body_velocity_step i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.force_x    (force_x),
		.force_y    (force_y),
		.frame_time (frame_time),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.velocity_x (velocity_x),
		.velocity_y (velocity_y),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Mirror of the registers and the body state.
	longint unsigned mass_q, friction_q, side_lim_q, fall_lim_q;
	longint          grav_x_q, grav_y_q;
	bit              grounded_q;
	longint          force_sum_x, force_sum_y, speed_x, speed_y;

	velocity_t pending_velocities[$];
	int        errors;
	int        n_ticks, n_forces, n_results;
	int        sender_idle_pct, receiver_idle_pct;
	bit        hold_request;
	int        cycle_count;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles", cycle_count);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic report_mismatch(input string what, input longint expected,
			input longint actual);
		$display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what,
			expected, actual);
		errors++;
	endtask

	function automatic longint sat32(input longint v);
		return v > S32_MAX ? S32_MAX : (v < S32_MIN ? S32_MIN : v);
	endfunction

	function automatic longint unsigned magnitude(input longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// One frame of the velocity update: force, gravity, limits, friction.
	function automatic void step_frame(input longint dt);
		longint          m, vx, vy, ux, uy, p, fx, fy, sx, sy, lim;
		longint unsigned len, slen, fm, f;
		m  = mass_q == 0 ? 64'sd1 : longint'(mass_q);
		vx = sat32(speed_x + (force_sum_x * dt) / m);
		vy = sat32(speed_y + (force_sum_y * dt) / m);
		len = int_sqrt(magnitude(grav_x_q) * magnitude(grav_x_q)
			+ magnitude(grav_y_q) * magnitude(grav_y_q));
		ux = 0;
		uy = 0;
		if (len != 0) begin
			ux = (grav_x_q * (64'sd1 <<< UNIT)) / longint'(len);
			uy = (grav_y_q * (64'sd1 <<< UNIT)) / longint'(len);
		end
		// Ground removes the part along gravity; air falls by gravity*dt.
		if (grounded_q) begin
			p  = (ux * vx + uy * vy) >>> UNIT;
			vx = sat32(vx - ((ux * p) >>> UNIT));
			vy = sat32(vy - ((uy * p) >>> UNIT));
		end else begin
			vx = sat32(vx - ((grav_x_q * dt) >>> FRAC));
			vy = sat32(vy - ((grav_y_q * dt) >>> FRAC));
		end
		// Split into fall and side parts and clamp each.
		p  = (ux * vx + uy * vy) >>> UNIT;
		fx = (ux * p) >>> UNIT;
		fy = (uy * p) >>> UNIT;
		sx = sat32(vx - fx);
		sy = sat32(vy - fy);
		if (magnitude(p) > fall_lim_q) begin
			lim = p < 0 ? -longint'(fall_lim_q) : longint'(fall_lim_q);
			fx  = (ux * lim) >>> UNIT;
			fy  = (uy * lim) >>> UNIT;
		end
		slen = int_sqrt(magnitude(sx) * magnitude(sx) + magnitude(sy) * magnitude(sy));
		if (slen > side_lim_q) begin
			sx = (sx * longint'(side_lim_q)) / longint'(slen);
			sy = (sy * longint'(side_lim_q)) / longint'(slen);
		end
		vx = sat32(fx + sx);
		vy = sat32(fy + sy);
		// Friction against the motion, stopping at zero.
		if (vx != 0 || vy != 0) begin
			fm = (friction_q * longint'(m)) >> FRAC;
			if (dt != 0 && fm > 64'hFFFF_FFFF_FFFF_FFFF / longint'(dt))
				f = 64'd1 << 40;
			else
				f = (fm * longint'(dt)) >> FRAC;
			len = int_sqrt(magnitude(vx) * magnitude(vx) + magnitude(vy) * magnitude(vy));
			if (len < f) begin
				vx = 0;
				vy = 0;
			end else begin
				vx -= (vx * longint'(f)) / longint'(len);
				vy -= (vy * longint'(f)) / longint'(len);
			end
		end
		speed_x = vx;
		speed_y = vy;
	endfunction

	function automatic velocity_t predict_velocity(input op_e op, input logic signed [31:0] fx,
			input logic signed [31:0] fy, input logic [16:0] dt);
		velocity_t v;
		if (op == OP_TICK) begin
			step_frame(longint'(dt));
		end else begin
			force_sum_x = sat32(force_sum_x + longint'(fx));
			force_sum_y = sat32(force_sum_y + longint'(fy));
		end
		v.vx = speed_x[31:0];
		v.vy = speed_y[31:0];
		return v;
	endfunction

	// Register write while the block is idle; the mirror follows.
	task automatic write_reg(input reg_e idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MASS:       mass_q     = value[30:0];
			REG_FRICTION:   friction_q = value[30:0];
			REG_SIDE_LIMIT: side_lim_q = value[30:0];
			REG_FALL_LIMIT: fall_lim_q = value[30:0];
			REG_GRAVITY_X:  grav_x_q   = longint'(signed'(value));
			REG_GRAVITY_Y:  grav_y_q   = longint'(signed'(value));
			REG_ON_GROUND:  grounded_q = value[0];
			default: ;
		endcase
	endtask

	// Offer one transaction, wait for acceptance and record its velocity.
	task automatic send_item(input row_t r);
		velocity_t v;
		int gap;
		if ($urandom_range(99) < sender_idle_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= r.op;
		force_x    <= r.fx;
		force_y    <= r.fy;
		frame_time <= r.dt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		v = predict_velocity(r.op, r.fx, r.fy, r.dt);
		if (r.typed) begin
			if (v.vx !== r.ex) report_mismatch("typed velocity_x", signed'(r.ex), v.vx);
			if (v.vy !== r.ey) report_mismatch("typed velocity_y", signed'(r.ey), v.vy);
		end
		pending_velocities.push_back(v);
		if (r.op == OP_TICK) n_ticks++;
		else n_forces++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_velocities.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] random_force();
		case ($urandom_range(9))
			0: return $urandom();
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			default: return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
		endcase
	endfunction

	function automatic logic [16:0] random_dt();
		case ($urandom_range(9))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'($urandom());
			default: return 17'($urandom_range(1, 4096));
		endcase
	endfunction

	function automatic logic [31:0] random_signed(input int bits);
		return 32'($urandom_range(0, (1 << bits) - 1)) - 32'(1 << (bits - 1));
	endfunction

	// Register settings of one random phase; the first three hold the extremes.
	task automatic configure_phase(input int ph);
		case (ph)
			0: begin
				// Zero mass, no friction, open limits.
				write_reg(REG_MASS, 32'd0);
				write_reg(REG_FRICTION, 32'd0);
				write_reg(REG_SIDE_LIMIT, 32'h7FFF_FFFF);
				write_reg(REG_FALL_LIMIT, 32'h7FFF_FFFF);
				write_reg(REG_GRAVITY_X, 32'd0);
				write_reg(REG_GRAVITY_Y, 32'd110 << FRAC);
				write_reg(REG_ON_GROUND, 32'd1);
			end
			1: begin
				// Huge friction, closed limits, extreme gravity in the air.
				write_reg(REG_MASS, 32'h7FFF_FFFF);
				write_reg(REG_FRICTION, 32'h7FFF_FFFF);
				write_reg(REG_SIDE_LIMIT, 32'd0);
				write_reg(REG_FALL_LIMIT, 32'd0);
				write_reg(REG_GRAVITY_X, 32'h8000_0000);
				write_reg(REG_GRAVITY_Y, 32'h8000_0000);
				write_reg(REG_ON_GROUND, 32'd0);
			end
			2: begin
				// Zero gravity in the air.
				write_reg(REG_MASS, 32'd1);
				write_reg(REG_FRICTION, 32'($urandom_range(0, 1 << 12)));
				write_reg(REG_SIDE_LIMIT, 32'($urandom_range(0, 1 << 28)));
				write_reg(REG_FALL_LIMIT, 32'($urandom_range(0, 1 << 28)));
				write_reg(REG_GRAVITY_X, 32'd0);
				write_reg(REG_GRAVITY_Y, 32'd0);
				write_reg(REG_ON_GROUND, 32'd0);
			end
			default: begin
				write_reg(REG_MASS, 32'($urandom_range(1 << 12, 1 << 22)));
				write_reg(REG_FRICTION, 32'($urandom_range(0, 1 << 20)));
				write_reg(REG_SIDE_LIMIT, 32'($urandom_range(0, 1 << 26)));
				write_reg(REG_FALL_LIMIT, 32'($urandom_range(0, 1 << 28)));
				write_reg(REG_GRAVITY_X, random_signed($urandom_range(2, 28)));
				write_reg(REG_GRAVITY_Y, random_signed($urandom_range(2, 28)));
				write_reg(REG_ON_GROUND, 32'($urandom_range(1)));
			end
		endcase
	endtask

	// Output side: check each transaction, then decide the next stall.
	initial begin
		velocity_t exp_v;
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				n_results++;
				if (pending_velocities.size() == 0) begin
					$display("[%0t] MISMATCH unexpected output transaction", $realtime);
					errors++;
				end else begin
					exp_v = pending_velocities.pop_front();
					if (velocity_x !== exp_v.vx)
						report_mismatch("velocity_x", exp_v.vx, velocity_x);
					if (velocity_y !== exp_v.vy)
						report_mismatch("velocity_y", exp_v.vy, velocity_y);
				end
			end
			if (hold_request && hold_left == 0) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < receiver_idle_pct);
			end
		end
	end

	// Stimulus.
	initial begin
		row_t directed[$];
		row_t r;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		operation  = OP_ADD_FORCE;
		force_x    = '0;
		force_y    = '0;
		frame_time = '0;
		out_stall  = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_MASS;
		cfg_data   = '0;
		errors = 0;
		n_ticks = 0;
		n_forces = 0;
		n_results = 0;
		hold_request = 1'b0;
		sender_idle_pct = 6;
		receiver_idle_pct = 83;
		mass_q = 64'd1 << FRAC;
		friction_q = 64'd100 << FRAC;
		side_lim_q = 64'd200 << FRAC;
		fall_lim_q = 64'd1000 << FRAC;
		grav_x_q = 0;
		grav_y_q = 64'sd110 <<< FRAC;
		grounded_q = 1'b1;
		force_sum_x = 0;
		force_sum_y = 0;
		speed_x = 0;
		speed_y = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows; velocity stays zero until the first tick with time.
		directed = '{
			'{OP_ADD_FORCE, 32'h0, 32'h0, 17'd0, 1'b1, 32'h0, 32'h0},
			'{OP_ADD_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 17'd0, 1'b1, 32'h0, 32'h0},
			'{OP_ADD_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 17'd0, 1'b1, 32'h0, 32'h0},
			'{OP_ADD_FORCE, 32'h8000_0000, 32'h7FFF_FFFF, 17'd0, 1'b1, 32'h0, 32'h0},
			'{OP_TICK, 32'h0, 32'h0, 17'd0, 1'b1, 32'h0, 32'h0},
			'{OP_ADD_FORCE, 32'h0100_0000, 32'hFF00_0000, 17'd0, 1'b0, 32'h0, 32'h0},
			'{OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd65536, 1'b0, 32'h0, 32'h0},
			'{OP_TICK, 32'h0, 32'h0, 17'h1FFFF, 1'b0, 32'h0, 32'h0},
			'{OP_TICK, 32'h0, 32'h0, 17'd1, 1'b0, 32'h0, 32'h0},
			'{OP_ADD_FORCE, 32'h8000_0000, 32'h8000_0000, 17'h1FFFF, 1'b0, 32'h0, 32'h0},
			'{OP_TICK, 32'h0, 32'h0, 17'd4096, 1'b0, 32'h0, 32'h0},
			'{OP_ADD_FORCE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd0, 1'b0, 32'h0, 32'h0},
			'{OP_TICK, 32'h0, 32'h0, 17'd32768, 1'b0, 32'h0, 32'h0}
		};
		foreach (directed[i]) send_item(directed[i]);
		wait_drained();

		// Random phases under changing settings and idling patterns.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 3) begin
				sender_idle_pct = 83;
				receiver_idle_pct = 6;
			end else if (ph == 6) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			configure_phase(ph);
			if (ph == 3) hold_request = 1'b1;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// Keep the input busy with force items while the output holds off.
				r.op = (ph == 3 && k < 40) ? OP_ADD_FORCE
					: ($urandom_range(99) < 40 ? OP_TICK : OP_ADD_FORCE);
				r.fx = random_force();
				r.fy = random_force();
				r.dt = random_dt();
				r.typed = 1'b0;
				r.ex = '0;
				r.ey = '0;
				send_item(r);
			end
			wait_drained();
		end

		$display("Covered %0d force and %0d tick transactions, %0d results checked,",
			n_forces, n_ticks, n_results);
		$display("over %0d register settings with sender and receiver idling.", PHASES + 1);
		if (errors == 0 && pending_velocities.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
